@@ src/cfba_pkg.sv @@
// Shared types, constants and helper functions for the chunked free-list
// block allocator. No dependencies; imported by every file but cfba_ram.
package cfba_pkg;

  localparam int MAX_CHUNKS        = 16;
  localparam int MAX_CHUNK_ENTRIES = 64;
  localparam int POOL_BLOCKS       = MAX_CHUNKS * MAX_CHUNK_ENTRIES;

  localparam int IDX_W   = $clog2(POOL_BLOCKS);
  localparam int LINK_W  = 11;
  localparam int AVAIL_W = 11;
  localparam int CHUNK_W = $clog2(MAX_CHUNKS + 1);
  localparam int ENT_W   = $clog2(MAX_CHUNK_ENTRIES + 1);
  localparam int BS_W    = 13;
  localparam int ADDR_W  = 22;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = BS_W;
  localparam int CE_RAW_W   = 7;

  localparam logic [LINK_W-1:0]  LINK_NONE = '1;
  localparam logic [AVAIL_W-1:0] AVAIL_MAX = '1;
  localparam logic [BS_W-1:0]    MIN_BLOCK = BS_W'(8);
  localparam logic [BS_W-1:0]    MAX_BLOCK = BS_W'(4096);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_FREE     = 2'd1,
    CMD_FREE_ALL = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_CHUNK = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE    = 2'd0,
    REG_CHUNK_ENTRIES = 2'd1
  } reg_idx_t;

  function automatic logic [BS_W-1:0] eff_size(input logic [BS_W-1:0] raw);
    logic [BS_W-1:0] s;
    s = raw;
    if (s < MIN_BLOCK) s = MIN_BLOCK;
    if (s > MAX_BLOCK) s = MAX_BLOCK;
    return s;
  endfunction

  function automatic logic [ENT_W-1:0] eff_entries(input logic [CE_RAW_W-1:0] raw);
    logic [ENT_W-1:0] e;
    e = ENT_W'(raw);
    if (raw == '0) e = ENT_W'(1);
    if (raw > CE_RAW_W'(MAX_CHUNK_ENTRIES)) e = ENT_W'(MAX_CHUNK_ENTRIES);
    return e;
  endfunction

endpackage

@@ src/chunked_free_list_block_allocator.sv @@
// Top level of the chunked free-list block allocator: control sequencer,
// state registers and the link memory. Depends on cfba_pkg, cfba_ram, cfba_div.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+--------------------------------------------
//  input    | in_valid / in_stall    | cmd, block_address
//  result   | out_valid / out_stall  | status, block_index, block_offset, free_count
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One command is worked at a time. Allocate from a non-empty list does one
// link-memory read; a grow first writes one link per chunk entry, then reads
// the new head entry. Free waits on the one-bit-per-cycle divider over 22 bits.
// Free-all, ignored commands and out-of-chunk allocates go straight to S_FINISH.
// Reset is synchronous; the link memory is not cleared. A stalled result does
// not close the input: the next command is worked and then waits in its final
// state until the earlier word is taken.
module chunked_free_list_block_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cfba_pkg::CMD_W-1:0]      cmd,
  input  logic [cfba_pkg::ADDR_W-1:0]     block_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cfba_pkg::STAT_W-1:0]     status,
  output logic [cfba_pkg::IDX_W-1:0]      block_index,
  output logic [cfba_pkg::ADDR_W-1:0]     block_offset,
  output logic [cfba_pkg::AVAIL_W-1:0]    free_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cfba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfba_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cfba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GROW,
    S_ALLOC_RD,
    S_ALLOC_WAIT,
    S_DIV,
    S_FREE_CHK,
    S_FINISH
  } state_t;

  state_t               state;
  logic [BS_W-1:0]      size_cfg;
  logic [CE_RAW_W-1:0]  chunk_entries;
  logic [LINK_W-1:0]    list_head;
  logic [AVAIL_W-1:0]   avail;
  logic [CHUNK_W-1:0]   chunks;

  logic [BS_W-1:0]      bs_q;
  logic [ENT_W-1:0]     ce_q;
  logic [AVAIL_W-1:0]   pool_blk;
  logic [ENT_W-1:0]     grow_i;
  logic [IDX_W-1:0]     res_idx;
  status_t              res_status;

  logic                 in_fire;
  logic                 out_of_chunks;
  logic [BS_W-1:0]      bs_now;
  logic [ENT_W-1:0]     ce_now;
  logic [CHUNK_W+ENT_W-1:0] pool_prod;
  logic [IDX_W-1:0]     base;
  logic [LINK_W-1:0]    grow_next;
  logic                 grow_last;
  logic [AVAIL_W:0]     avail_grow;
  logic [IDX_W+BS_W-1:0] off_full;

  logic                 div_start;
  logic                 div_done;
  logic [ADDR_W-1:0]    quo;
  logic                 free_ok;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [LINK_W-1:0]    wr_data;
  logic [LINK_W-1:0]    rd_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;

  assign out_of_chunks = (list_head == LINK_NONE) && (chunks >= CHUNK_W'(MAX_CHUNKS));

  assign bs_now    = eff_size(size_cfg);
  assign ce_now    = eff_entries(chunk_entries);
  assign pool_prod = chunks * ce_now;

  assign base       = pool_blk[IDX_W-1:0];
  assign grow_last  = (grow_i == ce_q - ENT_W'(1));
  assign grow_next  = LINK_W'(base) + LINK_W'(grow_i) + LINK_W'(1);
  assign avail_grow = {1'b0, avail} + (AVAIL_W+1)'(ce_q);
  assign free_ok    = (quo < ADDR_W'(pool_blk));
  assign off_full   = res_idx * bs_q;

  assign div_start = in_fire && (cmd == CMD_FREE);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = quo[IDX_W-1:0];
    wr_data = list_head;
    unique case (state)
      S_GROW: begin
        wr_en   = 1'b1;
        wr_addr = base + IDX_W'(grow_i);
        wr_data = grow_last ? LINK_NONE : grow_next;
      end
      S_FREE_CHK: begin
        wr_en = free_ok;
      end
      default: ;
    endcase
  end

  cfba_ram #(
    .WIDTH(LINK_W),
    .DEPTH(POOL_BLOCKS)
  ) u_link (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(list_head[IDX_W-1:0]),
    .rd_data(rd_data)
  );

  cfba_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(block_address),
    .divisor (bs_now),
    .done    (div_done),
    .quotient(quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      size_cfg      <= BS_W'(8);
      chunk_entries <= CE_RAW_W'(64);
      list_head     <= LINK_NONE;
      avail         <= '0;
      chunks        <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BLOCK_SIZE) begin
          size_cfg <= cfg_data;
        end else if (cfg_index == REG_CHUNK_ENTRIES) begin
          chunk_entries <= cfg_data[CE_RAW_W-1:0];
        end
      end

      // The finishing state loads the next word itself.
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            bs_q       <= bs_now;
            ce_q       <= ce_now;
            pool_blk   <= pool_prod[AVAIL_W-1:0];
            grow_i     <= '0;
            res_idx    <= '0;
            res_status <= (cmd == CMD_ALLOC && out_of_chunks) ? ST_NO_CHUNK : ST_OK;
            unique case (cmd)
              CMD_ALLOC: begin
                if (list_head != LINK_NONE) begin
                  // The link memory is already reading the head entry.
                  state <= S_ALLOC_WAIT;
                end else if (out_of_chunks) begin
                  state <= S_FINISH;
                end else begin
                  state <= S_GROW;
                end
              end
              CMD_FREE: begin
                state <= S_DIV;
              end
              CMD_FREE_ALL: begin
                chunks    <= '0;
                avail     <= '0;
                list_head <= LINK_NONE;
                state     <= S_FINISH;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_GROW: begin
          grow_i <= grow_i + ENT_W'(1);
          if (grow_last) begin
            avail     <= avail_grow[AVAIL_W] ? AVAIL_MAX : avail_grow[AVAIL_W-1:0];
            chunks    <= chunks + CHUNK_W'(1);
            list_head <= LINK_W'(base);
            state     <= S_ALLOC_RD;
          end
        end
        S_ALLOC_RD: begin
          state <= S_ALLOC_WAIT;
        end
        S_ALLOC_WAIT: begin
          res_idx   <= list_head[IDX_W-1:0];
          list_head <= rd_data;
          if (avail != '0) begin
            avail <= avail - AVAIL_W'(1);
          end
          state <= S_FINISH;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_FREE_CHK;
          end
        end
        S_FREE_CHK: begin
          if (free_ok) begin
            res_idx   <= quo[IDX_W-1:0];
            list_head <= LINK_W'(quo[IDX_W-1:0]);
            if (avail != AVAIL_MAX) begin
              avail <= avail + AVAIL_W'(1);
            end
          end else begin
            res_status <= ST_BAD_ADDR;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            block_index  <= res_idx;
            block_offset <= off_full[ADDR_W-1:0];
            free_count   <= avail;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/cfba_ram.sv @@
// Generic simple dual-port RAM: one write port and one read port with a
// registered read. No dependencies.
module cfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/cfba_div.sv @@
// Restoring divider, one quotient bit per cycle, used to turn a byte offset
// into a block index. Depends on cfba_pkg.
module cfba_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cfba_pkg::ADDR_W-1:0] dividend,
  input  logic [cfba_pkg::BS_W-1:0]   divisor,
  output logic                       done,
  output logic [cfba_pkg::ADDR_W-1:0] quotient
);
  import cfba_pkg::*;

  localparam int CNT_W = $clog2(ADDR_W + 1);

  logic [BS_W-1:0]   rem;
  logic [BS_W-1:0]   dsr;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [BS_W:0]     shifted;
  logic [BS_W+1:0]   diff;

  assign shifted = {rem, quotient[ADDR_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(1));
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(ADDR_W);
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        // A clear top bit of the difference means the trial subtract fits.
        if (!diff[BS_W+1]) begin
          rem      <= diff[BS_W-1:0];
          quotient <= {quotient[ADDR_W-2:0], 1'b1};
        end else begin
          rem      <= shifted[BS_W-1:0];
          quotient <= {quotient[ADDR_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ src/cfba_checker.sv @@
// Port-level checker for the chunked free-list block allocator, bound to the
// top level. Depends on cfba_pkg.
module cfba_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [cfba_pkg::STAT_W-1:0]     status,
  input logic [cfba_pkg::IDX_W-1:0]      block_index,
  input logic [cfba_pkg::ADDR_W-1:0]     block_offset,
  input logic [cfba_pkg::AVAIL_W-1:0]    free_count
);
  import cfba_pkg::*;

  // A result word that is held back must not move.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(block_index)
      && $stable(block_offset) && $stable(free_count))
    else $error("result word changed while stalled");

  // Nothing comes out in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

  // A failed command reports no block.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NO_CHUNK || status == ST_BAD_ADDR)
      |-> block_index == '0 && block_offset == '0)
    else $error("failed command reported a block");

  // Commands are worked one at a time: an accepted word closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a command was in progress");

endmodule

bind chunked_free_list_block_allocator cfba_checker u_cfba_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for chunked_free_list_block_allocator.
// Needs cfba_pkg and the allocator RTL; a scoreboard class predicts every
// result word from its own copy of the free list, registers and chunk count.
import cfba_pkg::*;

typedef struct packed {
  status_t              status;
  logic [IDX_W-1:0]     index;
  logic [ADDR_W-1:0]    offset;
  logic [AVAIL_W-1:0]   count;
} alloc_result_t;

class alloc_scoreboard;
  logic [LINK_W-1:0]   link_mem [POOL_BLOCKS];
  logic [LINK_W-1:0]   head = LINK_NONE;
  int unsigned         avail = 0;
  int unsigned         chunks = 0;
  logic [BS_W-1:0]     size_reg = BS_W'(8);
  logic [CE_RAW_W-1:0] entries_reg = CE_RAW_W'(64);
  alloc_result_t       pending_results[$];
  // Byte offsets of blocks handed out and not yet given back.
  int unsigned         live[$];
  int errors = 0;
  int n_words = 0, n_alloc = 0, n_free = 0, n_exhausted = 0, n_rejected = 0;

  function int unsigned block_bytes();
    int unsigned s;
    s = size_reg;
    if (s < 8) s = 8;
    if (s > 4096) s = 4096;
    return s;
  endfunction

  function int unsigned chunk_blocks();
    int unsigned e;
    e = entries_reg;
    if (e < 1) e = 1;
    if (e > MAX_CHUNK_ENTRIES) e = MAX_CHUNK_ENTRIES;
    return e;
  endfunction

  function int unsigned pool_bytes();
    return chunks * chunk_blocks() * block_bytes();
  endfunction

  function void set_register(input reg_idx_t r, input logic [CFG_DATA_W-1:0] d);
    case (r)
      REG_BLOCK_SIZE: begin
        size_reg = d;
        live.delete();
      end
      REG_CHUNK_ENTRIES: entries_reg = d[CE_RAW_W-1:0];
      default: ;
    endcase
  endfunction

  function void predict_command(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a);
    alloc_result_t r;
    int unsigned bs, ce, base, idx, i;
    bit ok;
    bs = block_bytes();
    r.status = ST_OK;
    r.index = '0;
    r.offset = '0;
    n_words++;
    case (c)
      CMD_ALLOC: begin
        ok = 1;
        if (head == LINK_NONE) begin
          if (chunks >= MAX_CHUNKS) begin
            ok = 0;
          end else begin
            // Grow by one chunk, linked in ascending order.
            ce = chunk_blocks();
            base = chunks * ce;
            for (i = 0; i + 1 < ce; i++)
              link_mem[(base + i) % POOL_BLOCKS] = LINK_W'(base + i + 1);
            link_mem[(base + ce - 1) % POOL_BLOCKS] = LINK_NONE;
            if (avail + ce > AVAIL_MAX) avail = AVAIL_MAX;
            else avail += ce;
            chunks++;
            head = LINK_W'(base);
          end
        end
        if (!ok) begin
          r.status = ST_NO_CHUNK;
          n_exhausted++;
        end else begin
          idx = head % POOL_BLOCKS;
          head = link_mem[idx];
          if (avail > 0) avail--;
          r.index = IDX_W'(idx);
          r.offset = ADDR_W'(idx * bs);
          live.insert(live.size(), idx * bs);
          n_alloc++;
        end
      end
      CMD_FREE: begin
        if (a >= pool_bytes()) begin
          r.status = ST_BAD_ADDR;
          n_rejected++;
        end else begin
          idx = (a / bs) % POOL_BLOCKS;
          link_mem[idx] = head;
          head = LINK_W'(idx);
          if (avail < AVAIL_MAX) avail++;
          r.index = IDX_W'(idx);
          r.offset = ADDR_W'(idx * bs);
          n_free++;
        end
      end
      CMD_FREE_ALL: begin
        chunks = 0;
        avail = 0;
        head = LINK_NONE;
        live.delete();
      end
      default: ;
    endcase
    r.count = AVAIL_W'(avail);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function void check_result(input logic [STAT_W-1:0] st, input logic [IDX_W-1:0] idx,
                             input logic [ADDR_W-1:0] off, input logic [AVAIL_W-1:0] cnt);
    alloc_result_t e;
    if (pending_results.size() == 0) begin
      $error("result word with no command outstanding");
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (st !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, st);
      errors++;
    end
    if (idx !== e.index) begin
      $error("block_index: expected %0d, got %0d", e.index, idx);
      errors++;
    end
    if (off !== e.offset) begin
      $error("block_offset: expected %0d, got %0d", e.offset, off);
      errors++;
    end
    if (cnt !== e.count) begin
      $error("free_count: expected %0d, got %0d", e.count, cnt);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CMD_W-1:0] cmd = '0;
  logic [ADDR_W-1:0] block_address = '0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_stall, out_valid, cfg_ready;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0] block_index;
  logic [ADDR_W-1:0] block_offset;
  logic [AVAIL_W-1:0] free_count;

  bit idling = 1'b1;
  int stall_left = 0;
  int cycles = 0;
  int config_writes = 0;
  alloc_scoreboard sb;

  chunked_free_list_block_allocator uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .block_address(block_address),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .block_index(block_index), .block_offset(block_offset), .free_count(free_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("chunked_free_list_block_allocator: mismatch");
      $finish;
    end
  end

  // The result is checked before the new command is noted, so a stray word
  // cannot borrow the expectation of a command accepted on the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_result(status, block_index, block_offset, free_count);
      if (in_valid && !in_stall)
        sb.predict_command(cmd, block_address);
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(0, 10);
    end else begin
      out_stall = 1'b0;
    end
  end

  // All driving tasks start and end just after a falling edge.
  task automatic send_command(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a);
    int gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    cmd = c;
    block_address = a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_register(input reg_idx_t r, input logic [CFG_DATA_W-1:0] d);
    cfg_valid = 1'b1;
    cfg_index = r;
    cfg_data = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(r, d);
    config_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int p, n, r, k;
    int unsigned off;
    logic [CFG_DATA_W-1:0] bs_val, ce_val;
    sb = new;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Smallest block and one block per chunk, so the chunk limit comes soon.
    program_register(REG_BLOCK_SIZE, '0);
    program_register(REG_CHUNK_ENTRIES, '0);
    send_command(CMD_FREE, '0);
    send_command(CMD_UNUSED, '1);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_FREE, ADDR_W'(7));
    // Freeing block 0 twice leaves it linked to itself; the free count
    // then runs down to zero and stays there.
    send_command(CMD_FREE, '0);
    repeat (3) send_command(CMD_ALLOC, '1);
    send_command(CMD_FREE_ALL, '0);
    repeat (MAX_CHUNKS + 1) send_command(CMD_ALLOC, '0);
    send_command(CMD_FREE, ADDR_W'(127));
    send_command(CMD_FREE, ADDR_W'(128));
    send_command(CMD_FREE, '1);

    for (p = 0; p < PHASES; p++) begin
      wait_for_results();
      case (p)
        0: begin bs_val = 13'd8191; ce_val = 13'd127; end
        1: begin bs_val = 13'd4096; ce_val = 13'd1; end
        2: begin
          bs_val = CFG_DATA_W'($urandom_range(1, 4096));
          ce_val = CFG_DATA_W'($urandom_range(1, 64));
        end
        3: begin bs_val = 13'd1; ce_val = 13'd64; end
        4: begin bs_val = CFG_DATA_W'($urandom); ce_val = CFG_DATA_W'($urandom); end
        default: begin bs_val = 13'd8; ce_val = 13'd3; end
      endcase
      program_register(REG_BLOCK_SIZE, bs_val);
      program_register(REG_CHUNK_ENTRIES, ce_val);
      idling = (p != PHASES - 1);
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (p == 2 && n == PHASE_WORDS / 2) wait_for_results();
        r = $urandom_range(0, 99);
        if (r < 48 || (r < 78 && sb.live.size() == 0)) begin
          send_command(CMD_ALLOC, ADDR_W'($urandom));
        end else if (r < 78) begin
          // Mostly give back a block that is held; now and then keep it listed
          // so that it is freed twice, and sometimes point inside the block.
          k = $urandom_range(0, sb.live.size() - 1);
          off = sb.live[k];
          if ($urandom_range(0, 19) != 0) sb.live.delete(k);
          if ($urandom_range(0, 2) == 0) off += $urandom_range(0, sb.block_bytes() - 1);
          send_command(CMD_FREE, ADDR_W'(off));
        end else if (r < 88) begin
          send_command(CMD_FREE, ADDR_W'($urandom));
        end else if (r < 94) begin
          off = (sb.pool_bytes() == 0) ? 0 : $urandom_range(0, sb.pool_bytes() - 1);
          send_command(CMD_FREE, ADDR_W'(off));
        end else if (r < 97) begin
          send_command(CMD_UNUSED, ADDR_W'($urandom));
        end else begin
          send_command(CMD_FREE_ALL, ADDR_W'($urandom));
        end
      end
    end

    wait_for_results();
    repeat (80) @(posedge clk);
    $display("Covered %0d command words under %0d register writes: %0d allocations, %0d frees.",
             sb.n_words, config_writes, sb.n_alloc, sb.n_free);
    $display("Allocations refused for lack of chunks: %0d; frees refused outside the pool: %0d.",
             sb.n_exhausted, sb.n_rejected);
    if (sb.errors == 0) begin
      $display("chunked_free_list_block_allocator: match");
    end else begin
      $display("chunked_free_list_block_allocator: mismatch");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
src/cfba_pkg.sv
src/cfba_ram.sv
src/cfba_div.sv
src/chunked_free_list_block_allocator.sv
src/cfba_checker.sv
sim/testbench.sv
